/* rtl/nfc_pkg.sv */
package nfc_pkg;

    // Round count and fixed widths
    localparam int unsigned ROUNDS_DEFAULT = 72;
    localparam int unsigned WORD_W         = 64;
    localparam int unsigned REG_IDX_W      = 3;

    typedef logic [3:0][WORD_W-1:0] block_t;
    typedef logic [7:0][WORD_W-1:0] sched_t;

    // Register map, in units of 64-bit registers
    localparam logic [REG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IV0  = 3'd4;

    // Initial key schedule words
    localparam sched_t INIT_WORDS = {
        64'hf49868f3bbc76141, 64'hbcf86e0d3dc199bb,
        64'hf8882200cdb4f256, 64'h8275e501f230b8d5,
        64'hbe4f3c1f65e2125d, 64'hcfbbc9437bcd9379,
        64'h8268adc2d69397b9, 64'ha00f3050f2a18c8f
    };

    // Request type carried in tuser
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_FETCH,
        ST_ROUND,
        ST_DONE
    } state_t;

    // Configuration write request
    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    data;
    } cfg_wr_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic sched_step;
        logic rk_we;
        logic round_en;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic dec;
    } dp_status_t;

    function automatic logic [WORD_W-1:0] rol64(input logic [WORD_W-1:0] x,
                                                input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

/* rtl/nonlinear_feistel_cipher_256_cbc.sv */
// Flow: an accepted request runs key expansion (first request after reset or a key
// write only), then a fetch state, the round state for each round, and a done
// state that registers the result once the output is free. One block is in flight
// at a time (single round unit, CBC chain); one round key row is read per cycle.
// Reset: aresetn synchronous, active low; clears control, key, IV and chain.
// Round key memory is not cleared; it is always rebuilt before use.
module nonlinear_feistel_cipher_256_cbc #(
    parameter int unsigned ROUNDS = nfc_pkg::ROUNDS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [5:0]                    paddr,
    input  logic [nfc_pkg::WORD_W-1:0]    pwdata,
    output logic [nfc_pkg::WORD_W-1:0]    prdata,
    output logic                          pready,
    // Input request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [255:0]                  s_tdata,  // in_word0..in_word3
    input  logic [1:0]                    s_tuser,  // req_type, first_block
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [255:0]                  m_tdata   // out_word0..out_word3
);
    import nfc_pkg::*;

    localparam int unsigned CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    cfg_wr_t          cfg;
    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [CNT_W-1:0] rk_waddr, rk_raddr;
    logic             key_wr;
    block_t           out_block;

    // APB decode: one 64-bit register every 8 bytes
    assign pready   = 1'b1;
    assign cfg.we   = psel & penable & pwrite;
    assign cfg.idx  = paddr[5:3];
    assign cfg.data = pwdata;
    assign key_wr   = cfg.we && (cfg.idx < REG_IV0);

    nfc_ctrl #(.ROUNDS(ROUNDS), .CNT_W(CNT_W)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .key_wr   (key_wr),
        .status   (status),
        .cmd      (cmd),
        .rk_waddr (rk_waddr),
        .rk_raddr (rk_raddr)
    );

    nfc_dp #(.ROUNDS(ROUNDS), .CNT_W(CNT_W)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .rk_waddr  (rk_waddr),
        .rk_raddr  (rk_raddr),
        .cfg       (cfg),
        .rd_idx    (paddr[5:3]),
        .rd_data   (prdata),
        .in_block  (block_t'(s_tdata)),
        .in_flags  (s_tuser),
        .out_block (out_block)
    );

    assign m_tdata = 256'(out_block);

endmodule

/* rtl/nfc_ctrl.sv */
module nfc_ctrl #(
    parameter int unsigned ROUNDS = nfc_pkg::ROUNDS_DEFAULT,
    parameter int unsigned CNT_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               key_wr,
    input  nfc_pkg::dp_status_t status,
    output nfc_pkg::dp_cmd_t   cmd,
    output logic [CNT_W-1:0]   rk_waddr,
    output logic [CNT_W-1:0]   rk_raddr
);
    import nfc_pkg::*;

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(ROUNDS - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] raddr_reg, raddr_next;
    logic             ready_reg, ready_next;
    logic             mvalid_reg, mvalid_next;

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            raddr_reg  <= '0;
            ready_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            raddr_reg  <= raddr_next;
            ready_reg  <= ready_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        raddr_next  = raddr_reg;
        ready_next  = ready_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        s_tready    = 1'b0;

        if (mvalid_reg && m_tready) mvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    // stale round keys are rebuilt first
                    state_next = ready_reg ? ST_FETCH : ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                cmd.sched_step = 1'b1;
                cmd.rk_we      = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    ready_next = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // decrypt walks the round keys backwards
                raddr_next = status.dec ? LAST_IDX : '0;
                cnt_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    raddr_next = status.dec ? raddr_reg - 1'b1 : raddr_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.finish  = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (key_wr) ready_next = 1'b0;
    end

    assign m_tvalid = mvalid_reg;
    assign rk_waddr = cnt_reg;
    assign rk_raddr = raddr_next;

endmodule

/* rtl/nfc_dp.sv */
module nfc_dp #(
    parameter int unsigned ROUNDS = nfc_pkg::ROUNDS_DEFAULT,
    parameter int unsigned CNT_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  nfc_pkg::dp_cmd_t                  cmd,
    output nfc_pkg::dp_status_t               status,
    input  logic [CNT_W-1:0]                  rk_waddr,
    input  logic [CNT_W-1:0]                  rk_raddr,
    input  nfc_pkg::cfg_wr_t                  cfg,
    input  logic [nfc_pkg::REG_IDX_W-1:0]     rd_idx,
    output logic [nfc_pkg::WORD_W-1:0]        rd_data,
    input  nfc_pkg::block_t                   in_block,
    input  logic [1:0]                        in_flags,
    output nfc_pkg::block_t                   out_block
);
    import nfc_pkg::*;

    block_t key_reg, iv_reg, chain_reg, work_reg, ct_reg, out_reg, rk_q;
    sched_t sched_reg, sched_upd;
    logic   dec_reg;
    block_t rk_mem [ROUNDS];
    block_t chain_sel, rk_new, enc_out, dec_out, t;
    logic [WORD_W-1:0] m0, m1;

    // Key schedule update
    always_comb begin
        sched_t r;
        r = sched_reg;
        r[0] = r[0] ^ (~rol64(r[4], 2) & rol64(r[5], 3));
        r[1] = r[1] ^ (~r[5] & rol64(r[4], 6));
        r[2] = r[2] ^ (~rol64(r[7], 4) & r[6]);
        r[3] = r[3] ^ (~rol64(r[6], 11) & rol64(r[7], 8));
        r[4] = r[4] ^ r[7];
        r[5] = r[5] ^ r[4];
        r[6] = r[6] ^ r[5];
        r[7] = r[7] ^ r[6];
        for (int i = 0; i < 4; i++) begin
            sched_upd[i]     = r[i + 4];
            sched_upd[i + 4] = r[i];
        end
        for (int i = 0; i < 4; i++) rk_new[i] = sched_upd[i] ^ sched_upd[i + 4];
    end

    // Encrypt round: mix, add round key, swap halves
    always_comb begin
        m0 = work_reg[0] ^ (~rol64(work_reg[2], 3) & rol64(work_reg[3], 7));
        m1 = work_reg[1] ^ (~work_reg[3] & rol64(work_reg[2], 13));
        enc_out[0] = work_reg[2] ^ rk_q[2];
        enc_out[1] = work_reg[3] ^ rk_q[3];
        enc_out[2] = m0 ^ rk_q[0];
        enc_out[3] = m1 ^ rk_q[1];
    end

    // Decrypt round: swap halves, add round key, mix
    always_comb begin
        t[0] = work_reg[2] ^ rk_q[0];
        t[1] = work_reg[3] ^ rk_q[1];
        t[2] = work_reg[0] ^ rk_q[2];
        t[3] = work_reg[1] ^ rk_q[3];
        dec_out[0] = t[0] ^ (~rol64(t[2], 3) & rol64(t[3], 7));
        dec_out[1] = t[1] ^ (~t[3] & rol64(t[2], 13));
        dec_out[2] = t[2];
        dec_out[3] = t[3];
    end

    assign chain_sel = in_flags[1] ? iv_reg : chain_reg;

    // Configuration registers and chaining value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            iv_reg    <= '0;
            chain_reg <= '0;
        end else begin
            if (cfg.we) begin
                if (cfg.idx < REG_IV0) key_reg[cfg.idx[1:0]] <= cfg.data;
                else                   iv_reg[cfg.idx[1:0]]  <= cfg.data;
            end
            if (cmd.load)   chain_reg <= chain_sel;
            if (cmd.finish) chain_reg <= dec_reg ? ct_reg : work_reg;
        end
    end

    // Block, schedule and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dec_reg  <= in_flags[0];
            ct_reg   <= in_block;
            work_reg <= (in_flags[0] == REQ_DECRYPT) ? in_block : in_block ^ chain_sel;
            for (int i = 0; i < 8; i++) begin
                sched_reg[i] <= (i < 4) ? INIT_WORDS[i] ^ key_reg[i[1:0]] : INIT_WORDS[i];
            end
        end
        if (cmd.sched_step) sched_reg <= sched_upd;
        if (cmd.round_en)   work_reg  <= dec_reg ? dec_out : enc_out;
        if (cmd.finish)     out_reg   <= dec_reg ? work_reg ^ chain_reg : work_reg;
    end

    // Round key memory, one row per round
    always_ff @(posedge aclk) begin
        if (cmd.rk_we) rk_mem[rk_waddr] <= rk_new;
        rk_q <= rk_mem[rk_raddr];
    end

    assign rd_data    = (rd_idx < REG_IV0) ? key_reg[rd_idx[1:0]] : iv_reg[rd_idx[1:0]];
    assign out_block  = out_reg;
    assign status.dec = dec_reg;

endmodule

/* rtl/nfc_checker.sv */
module nfc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [255:0] m_tdata,
    input logic         pready
);

    // A held result stays offered
    a_mvalid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A held result keeps its data
    a_mdata_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // One block at a time: busy after taking a request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !($rose(m_tvalid)))
        else $error("request accepted while a block is in flight");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Config port never stalls
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind nonlinear_feistel_cipher_256_cbc nfc_checker u_nfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
